>>> hdl/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg
// Shared sizes, codes and the exponential gain table of the SOM learner.
// ----------------------------------------------------------------------------
package som_pkg;

   // codebook geometry
   localparam int NUM_ENTRIES     = 64;
   localparam int MAX_VECTOR_DIMS = 16;
   localparam int MAX_MAP_DIMS    = 2;

   localparam int ENT_W   = $clog2(NUM_ENTRIES);
   localparam int CNT_W   = $clog2(NUM_ENTRIES + 1);
   localparam int COMP_W  = $clog2(MAX_VECTOR_DIMS);
   localparam int DIMS_W  = $clog2(MAX_VECTOR_DIMS + 1);
   localparam int MCOMP_W = $clog2(MAX_MAP_DIMS);
   localparam int WADDR_W = ENT_W + COMP_W;
   localparam int CADDR_W = ENT_W + MCOMP_W;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_LOAD_WEIGHT = 2'd0,
      FUNC_LOAD_COORD  = 2'd1,
      FUNC_CLASSIFY    = 2'd2,
      FUNC_LEARN       = 2'd3
   } func_type;

   // register indexes (byte address = 8 * index)
   typedef enum logic [2:0] {
      CSR_ENTRY_COUNT  = 3'd0,
      CSR_VECTOR_DIMS  = 3'd1,
      CSR_MAP_DIMS     = 3'd2,
      CSR_LEARN_RAY    = 3'd3,
      CSR_LEARN_FACTOR = 3'd4,
      CSR_DENSITY_RAY  = 3'd5
   } csr_index_type;

   // exp(-i/256) in unsigned Q.16, built at elaboration
   typedef logic [16:0] exp_table_type [256];

   function automatic exp_table_type build_exp_table();
      exp_table_type tab;
      logic [64:0]   t;
      t = 65'd1 << 32;
      for (int i = 0; i < 256; i++) begin
         tab[i] = 17'((t + 65'd32768) >> 16);
         t      = (t * 65'd4278222805 + (65'd1 << 31)) >> 32;
      end
      return tab;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

>>> hdl/som_ifs.sv
// ----------------------------------------------------------------------------
// som request / response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface som_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [5:0]         entry_index;
   logic [3:0]         component_index;
   logic signed [15:0] value;
   logic               last_component;

   modport source (output valid, func, entry_index, component_index, value,
                   last_component, input ready);
   modport sink   (input valid, func, entry_index, component_index, value,
                   last_component, output ready);
endinterface

interface som_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  winner_index;
   logic [39:0] winner_sq_distance;
   logic [6:0]  density_count;
   logic        empty_map;

   modport source (output valid, winner_index, winner_sq_distance, density_count,
                   empty_map, input ready);
   modport sink   (input valid, winner_index, winner_sq_distance, density_count,
                   empty_map, output ready);
endinterface

>>> hdl/self_organizing_map_learner_core.sv
// ----------------------------------------------------------------------------
// self_organizing_map_learner_core
// Kohonen codebook: loads, winner search with density count, and learning.
// ----------------------------------------------------------------------------
// Loads and non-final query components are taken one beat per cycle while idle.
// Final query component: scan of n*dims weight reads through the single read
//   port and the scan pipeline; learn then reads the winner's coordinates,
//   then per entry its coordinates; inside the radius, divide, gain, update.
// Response is held in an output register; the next request waits for it only
//   when another response is ready. Sync reset sets config and control
//   registers to defaults; memories are undefined until written, no clearing pass.
module self_organizing_map_learner_core
   import som_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   som_req_if.sink     req_ch,
   som_rsp_if.source   rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_LWIN0, S_LWIN1, S_LENT0, S_LENT1,
      S_LMD, S_LDIV, S_LGAIN, S_LUPD, S_FINISH
   } state_type;

   // configuration registers
   logic [6:0]  ec_ff;
   logic [4:0]  vd_ff;
   logic [1:0]  md_ff;
   logic [15:0] ray_ff;
   logic [15:0] fac_ff;
   logic [39:0] dray_ff;

   // memories
   logic signed [15:0] wmem [NUM_ENTRIES*MAX_VECTOR_DIMS];
   logic [7:0]         cmem [NUM_ENTRIES*MAX_MAP_DIMS];
   logic signed [15:0] query_ff [MAX_VECTOR_DIMS];
   logic               w_we;
   logic [WADDR_W-1:0] w_waddr, w_raddr;
   logic signed [15:0] w_wdata, w_rdata_ff;
   logic               c_we;
   logic [CADDR_W-1:0] c_waddr, c_raddr;
   logic [7:0]         c_rdata_ff;

   // control
   state_type          state_ff, state_in;
   logic [ENT_W-1:0]   i_ff;
   logic [COMP_W-1:0]  j_ff;
   logic               issue_done_ff;
   logic               learn_ff, empty_ff;

   // scan pipeline
   logic               p1_valid_ff, p1_last_ff, p2_valid_ff, p2_last_ff;
   logic [ENT_W-1:0]   p1_ent_ff, p2_ent_ff;
   logic signed [15:0] p1_q_ff;
   logic [33:0]        sq_ff;
   logic [39:0]        acc_ff, best_ff;
   logic [ENT_W-1:0]   win_ff;
   logic [CNT_W-1:0]   dens_ff;

   // learn datapath
   logic [7:0]         wc0_ff, wc1_ff, c0_ff;
   logic [15:0]        rem_ff;
   logic [7:0]         quo_ff;
   logic [2:0]         div_cnt_ff;
   logic [20:0]        gain_ff;
   logic               u1_valid_ff, u2_valid_ff;
   logic [WADDR_W-1:0] u1_addr_ff, u2_addr_ff;
   logic signed [15:0] u1_q_ff, u2_w_ff;
   logic signed [38:0] prod_ff;

   // response register
   logic               rsp_valid_ff, rsp_empty_ff;
   logic [ENT_W-1:0]   rsp_win_ff;
   logic [39:0]        rsp_dist_ff;
   logic [CNT_W-1:0]   rsp_dens_ff;

   // effective configuration
   logic [CNT_W-1:0]   n_eff;
   logic [DIMS_W-1:0]  dims_eff;
   logic               two_map;

   always_comb begin
      n_eff    = (ec_ff > CNT_W'(NUM_ENTRIES)) ? CNT_W'(NUM_ENTRIES) : ec_ff;
      dims_eff = (vd_ff == '0) ? DIMS_W'(1) :
                 ((vd_ff > DIMS_W'(MAX_VECTOR_DIMS)) ? DIMS_W'(MAX_VECTOR_DIMS) : vd_ff);
      two_map  = (md_ff >= 2'd2);
   end

   // ---------------------------------------------------------------------
   // configuration port
   logic csr_wr;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_index_type'(csr_paddr[5:3]))
         CSR_ENTRY_COUNT:  csr_prdata = 64'(ec_ff);
         CSR_VECTOR_DIMS:  csr_prdata = 64'(vd_ff);
         CSR_MAP_DIMS:     csr_prdata = 64'(md_ff);
         CSR_LEARN_RAY:    csr_prdata = 64'(ray_ff);
         CSR_LEARN_FACTOR: csr_prdata = 64'(fac_ff);
         CSR_DENSITY_RAY:  csr_prdata = 64'(dray_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ec_ff   <= '0;
         vd_ff   <= 5'd1;
         md_ff   <= 2'd1;
         ray_ff  <= 16'd1280;
         fac_ff  <= 16'd4096;
         dray_ff <= 40'd327680;
      end else if (csr_wr) begin
         unique case (csr_index_type'(csr_paddr[5:3]))
            CSR_ENTRY_COUNT:  ec_ff   <= csr_pwdata[6:0];
            CSR_VECTOR_DIMS:  vd_ff   <= csr_pwdata[4:0];
            CSR_MAP_DIMS:     md_ff   <= csr_pwdata[1:0];
            CSR_LEARN_RAY:    ray_ff  <= csr_pwdata[15:0];
            CSR_LEARN_FACTOR: fac_ff  <= csr_pwdata[15:0];
            CSR_DENSITY_RAY:  dray_ff <= csr_pwdata[39:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // datapath helpers
   logic               req_acc;
   func_type           req_func;
   logic               last_j, last_ent;
   logic signed [16:0] sdiff;
   logic signed [33:0] sq_c;
   logic [39:0]        sum;
   logic               better;
   logic signed [8:0]  dx0, dx1;
   logic signed [17:0] mx0, mx1;
   logic [16:0]        md;
   logic               far;
   logic [16:0]        rem2;
   logic               ge;
   logic signed [16:0] udelta;
   logic signed [21:0] gain_s;
   logic signed [38:0] prod_c;
   logic signed [38:0] rnd, rsh;
   logic signed [23:0] nw;
   logic signed [15:0] nw_sat;
   logic               upd_done, scan_done, rsp_free;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_func     = func_type'(req_ch.func);

   always_comb begin
      last_j   = ({1'b0, j_ff} == dims_eff - DIMS_W'(1));
      last_ent = ({1'b0, i_ff} == n_eff - CNT_W'(1));
      // squared difference of one component
      sdiff    = 17'(p1_q_ff) - 17'(w_rdata_ff);
      sq_c     = sdiff * sdiff;
      sum      = acc_ff + 40'(sq_ff);
      better   = (p2_ent_ff == '0) || (sum < best_ff);
      // map distance to the winner
      dx0      = $signed({1'b0, c0_ff}) - $signed({1'b0, wc0_ff});
      dx1      = $signed({1'b0, c_rdata_ff}) - $signed({1'b0, wc1_ff});
      mx0      = dx0 * dx0;
      mx1      = dx1 * dx1;
      md       = mx0[16:0] + (two_map ? mx1[16:0] : 17'd0);
      far      = ({md, 8'd0} >= 25'(ray_ff));
      // restoring division step
      rem2     = {rem_ff, 1'b0};
      ge       = (rem2 >= 17'(ray_ff));
      // weight update, rounding half up and saturating
      udelta   = 17'(u1_q_ff) - 17'(w_rdata_ff);
      gain_s   = $signed({1'b0, gain_ff});
      prod_c   = udelta * gain_s;
      rnd      = prod_ff + 39'sd32768;
      rsh      = rnd >>> 16;
      nw       = $signed(rsh[23:0]) + $signed({{8{u2_w_ff[15]}}, u2_w_ff});
      if (nw > 24'sd32767)       nw_sat = 16'sh7FFF;
      else if (nw < -24'sd32768) nw_sat = 16'sh8000;
      else                       nw_sat = nw[15:0];
      scan_done = issue_done_ff && !p1_valid_ff && !p2_valid_ff;
      upd_done  = issue_done_ff && !u1_valid_ff && !u2_valid_ff;
      rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   end

   // memory port selection
   always_comb begin
      w_raddr = {i_ff, j_ff};
      w_we    = (req_acc && req_func == FUNC_LOAD_WEIGHT) || u2_valid_ff;
      w_waddr = u2_valid_ff ? u2_addr_ff : {req_ch.entry_index, req_ch.component_index};
      w_wdata = u2_valid_ff ? nw_sat : req_ch.value;
      // coordinate positions beyond the map are dropped
      c_we    = req_acc && req_func == FUNC_LOAD_COORD &&
                (req_ch.component_index[3:MCOMP_W] == '0);
      c_waddr = {req_ch.entry_index, req_ch.component_index[MCOMP_W-1:0]};
      unique case (state_ff)
         S_LWIN0: c_raddr = {win_ff, 1'b0};
         S_LWIN1: c_raddr = {win_ff, 1'b1};
         S_LENT0: c_raddr = {i_ff, 1'b0};
         default: c_raddr = {i_ff, 1'b1};
      endcase
   end

   always_ff @(posedge clock) begin
      if (w_we) wmem[w_waddr] <= w_wdata;
      w_rdata_ff <= wmem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (c_we) cmem[c_waddr] <= req_ch.value[7:0];
      c_rdata_ff <= cmem[c_raddr];
   end

   // ---------------------------------------------------------------------
   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:
            if (req_acc && req_ch.last_component &&
                (req_func == FUNC_CLASSIFY || req_func == FUNC_LEARN))
               state_in = (n_eff == '0) ? S_FINISH : S_SCAN;
         S_SCAN:
            if (scan_done)
               state_in = (learn_ff && ray_ff != '0) ? S_LWIN0 : S_FINISH;
         S_LWIN0: state_in = S_LWIN1;
         S_LWIN1: state_in = S_LENT0;
         S_LENT0: state_in = S_LENT1;
         S_LENT1: state_in = S_LMD;
         S_LMD:
            if (!far)         state_in = S_LDIV;
            else if (last_ent) state_in = S_FINISH;
            else               state_in = S_LENT0;
         S_LDIV:  if (div_cnt_ff == 3'd7) state_in = S_LGAIN;
         S_LGAIN: state_in = S_LUPD;
         S_LUPD:
            if (upd_done) state_in = last_ent ? S_FINISH : S_LENT0;
         S_FINISH: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // state, counters, pipelines and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         issue_done_ff <= 1'b0;
         p1_valid_ff   <= 1'b0;
         p2_valid_ff   <= 1'b0;
         u1_valid_ff   <= 1'b0;
         u2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // a new response beat replaces the one taken in the same cycle
         if (state_ff == S_FINISH && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready)                rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_acc && (req_func == FUNC_CLASSIFY || req_func == FUNC_LEARN)) begin
                  query_ff[req_ch.component_index] <= req_ch.value;
                  learn_ff      <= (req_func == FUNC_LEARN);
                  empty_ff      <= (n_eff == '0);
                  i_ff          <= '0;
                  j_ff          <= '0;
                  issue_done_ff <= 1'b0;
                  acc_ff        <= '0;
                  dens_ff       <= '0;
               end
            end
            S_SCAN: begin
               if (!issue_done_ff) begin
                  j_ff <= last_j ? '0 : j_ff + 1'b1;
                  if (last_j) begin
                     if (last_ent) issue_done_ff <= 1'b1;
                     else          i_ff <= i_ff + 1'b1;
                  end
               end
               if (scan_done) i_ff <= '0;
            end
            S_LWIN1: wc0_ff <= c_rdata_ff;
            S_LENT0: begin
               // winner's second coordinate lands here on the first entry only
               if (i_ff == '0) wc1_ff <= c_rdata_ff;
            end
            S_LENT1: c0_ff <= c_rdata_ff;
            S_LMD: begin
               rem_ff     <= {md[7:0], 8'd0};
               quo_ff     <= '0;
               div_cnt_ff <= '0;
               if (far && !last_ent) i_ff <= i_ff + 1'b1;
            end
            S_LDIV: begin
               rem_ff     <= ge ? 16'(rem2 - 17'(ray_ff)) : rem2[15:0];
               quo_ff     <= {quo_ff[6:0], ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
            end
            S_LGAIN: begin
               gain_ff       <= 21'((33'(fac_ff) * 33'(EXP_TABLE[quo_ff]) + 33'd2048) >> 12);
               j_ff          <= '0;
               issue_done_ff <= 1'b0;
            end
            S_LUPD: begin
               if (!issue_done_ff) begin
                  j_ff <= last_j ? '0 : j_ff + 1'b1;
                  if (last_j) issue_done_ff <= 1'b1;
               end
               if (upd_done && !last_ent) i_ff <= i_ff + 1'b1;
            end
            S_FINISH: begin
               if (rsp_free) begin
                  rsp_empty_ff <= empty_ff;
                  rsp_win_ff   <= empty_ff ? '0 : win_ff;
                  rsp_dist_ff  <= empty_ff ? '0 : best_ff;
                  rsp_dens_ff  <= empty_ff ? '0 : dens_ff;
               end
            end
            default: ;
         endcase

         // scan stage 1: weight read returns with its query component
         p1_valid_ff <= (state_ff == S_SCAN) && !issue_done_ff;
         p1_last_ff  <= last_j;
         p1_ent_ff   <= i_ff;
         p1_q_ff     <= query_ff[j_ff];
         // scan stage 2: squared difference
         p2_valid_ff <= p1_valid_ff;
         p2_last_ff  <= p1_last_ff;
         p2_ent_ff   <= p1_ent_ff;
         sq_ff       <= unsigned'(sq_c);
         // scan stage 3: accumulate and judge the finished entry
         if (p2_valid_ff) begin
            if (p2_last_ff) begin
               acc_ff <= '0;
               if (better) begin
                  best_ff <= sum;
                  win_ff  <= p2_ent_ff;
               end
               if (sum <= dray_ff) dens_ff <= dens_ff + 1'b1;
            end else begin
               acc_ff <= sum;
            end
         end

         // update stage 1: weight read with its query component
         u1_valid_ff <= (state_ff == S_LUPD) && !issue_done_ff;
         u1_addr_ff  <= {i_ff, j_ff};
         u1_q_ff     <= query_ff[j_ff];
         // update stage 2: pull product, written back next
         u2_valid_ff <= u1_valid_ff;
         u2_addr_ff  <= u1_addr_ff;
         u2_w_ff     <= w_rdata_ff;
         prod_ff     <= prod_c;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.winner_index       = rsp_win_ff;
   assign rsp_ch.winner_sq_distance = rsp_dist_ff;
   assign rsp_ch.density_count      = rsp_dens_ff;
   assign rsp_ch.empty_map          = rsp_empty_ff;

   // ---------------------------------------------------------------------
   // checks
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("response raised outside finish");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_dist_ff == '0 && rsp_dens_ff == '0)
      else $error("empty map response carries data");

   a_winner_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) && !empty_ff |->
         {1'b0, win_ff} < n_eff && dens_ff <= n_eff)
      else $error("winner or density beyond entry count");

endmodule

>>> tb/sv/tb_self_organizing_map_learner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_self_organizing_map_learner_core
// Drives codebook loads and classify/learn queries into the SOM core under
// several register settings. Every request beat is also fed to a local
// model of the codebook, and the response beats are checked in order
// against that model's winner, distance, density and empty flag.
// ----------------------------------------------------------------------------
module tb_self_organizing_map_learner_core;
   import som_pkg::*;

   localparam int  LIMIT = 1000000;
   localparam int  DRAIN = 4000;

   typedef struct {
      func_type           func;
      logic [5:0]         ent;
      logic [3:0]         comp;
      logic signed [15:0] val;
      logic               last;
   } som_req_type;

   typedef struct {
      logic [5:0]  win;
      logic [39:0] sqd;
      logic [6:0]  dens;
      logic        empty;
   } som_rsp_type;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata, csr_prdata;

   som_req_if req_ch();
   som_rsp_if rsp_ch();

   self_organizing_map_learner_core u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock: 12 ns period
   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // model state
   logic signed [15:0] cb_weight [64][16];
   logic [7:0]         cb_coord  [64][2];
   logic signed [15:0] query_vec [16];
   logic [16:0]        gain_exp  [256];
   logic [6:0]         r_count;
   logic [4:0]         r_vdims;
   logic [1:0]         r_mdims;
   logic [15:0]        r_lray, r_lfac;
   logic [39:0]        r_dray;

   // stimulus knowledge of what was written
   bit wr_weight [64][16];
   bit wr_coord  [64][2];
   bit wr_query  [16];

   som_req_type pending_beats [$];
   som_rsp_type expected_rsp  [$];
   int       errors;
   int       cycles;
   bit       calm;
   int       rsp_seen;

   function automatic int eff_count();
      return (r_count > 64) ? 64 : int'(r_count);
   endfunction
   function automatic int eff_vdims();
      return (r_vdims == 0) ? 1 : ((r_vdims > 16) ? 16 : int'(r_vdims));
   endfunction
   function automatic int eff_mdims();
      return (r_mdims == 0) ? 1 : ((r_mdims > 2) ? 2 : int'(r_mdims));
   endfunction

   // apply one accepted beat to the model, queue the response it causes
   function automatic void som_predict(som_req_type r);
      int                n, dims, mdims, win, dens;
      longint unsigned   best, d, md, idx, gain;
      longint            diff, v, nw;
      som_rsp_type       rsp;
      n = eff_count(); dims = eff_vdims(); mdims = eff_mdims();
      win = 0; dens = 0; best = 0;
      case (r.func)
         FUNC_LOAD_WEIGHT: begin
            cb_weight[r.ent][r.comp] = r.val;
            return;
         end
         FUNC_LOAD_COORD: begin
            if (r.comp < 2) cb_coord[r.ent][r.comp] = r.val[7:0];
            return;
         end
         default: ;
      endcase
      query_vec[r.comp] = r.val;
      if (!r.last) return;
      if (n == 0) begin
         rsp = '{win: '0, sqd: '0, dens: '0, empty: 1'b1};
         expected_rsp.insert(expected_rsp.size(), rsp);
         return;
      end
      for (int i = 0; i < n; i++) begin
         d = 0;
         for (int j = 0; j < dims; j++) begin
            diff = longint'(query_vec[j]) - longint'(cb_weight[i][j]);
            d += longint'(diff * diff);
         end
         if (d > 64'hFF_FFFF_FFFF) d = 64'hFF_FFFF_FFFF;
         if (i == 0 || d < best) begin
            best = d; win = i;
         end
         if (d <= r_dray) dens++;
      end
      // learn: pull entries near the winner on the map
      if (r.func == FUNC_LEARN && r_lray != 0) begin
         for (int i = 0; i < n; i++) begin
            md = 0;
            for (int j = 0; j < mdims; j++) begin
               diff = longint'(cb_coord[i][j]) - longint'(cb_coord[win][j]);
               md += longint'(diff * diff);
            end
            if (md * 256 >= r_lray) continue;
            idx = (md << 16) / r_lray;
            if (idx > 255) idx = 255;
            gain = (longint'(r_lfac) * gain_exp[idx] + 2048) >> 12;
            for (int j = 0; j < dims; j++) begin
               diff = longint'(query_vec[j]) - longint'(cb_weight[i][j]);
               v    = diff * longint'(gain) + 32768;
               nw   = longint'(cb_weight[i][j]) + (v >>> 16);
               if (nw > 32767) nw = 32767;
               if (nw < -32768) nw = -32768;
               cb_weight[i][j] = 16'(nw);
            end
         end
      end
      rsp = '{win: 6'(win), sqd: best[39:0], dens: 7'(dens), empty: 1'b0};
      expected_rsp.insert(expected_rsp.size(), rsp);
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("[%0t] response %0d: %s got 0x%0h expected 0x%0h",
               $time, rsp_seen, what, got, want);
   endtask

   // request driver
   som_req_type cur;
   int       req_gap;
   always @(posedge clock) begin
      logic        busy;
      som_req_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.func <= FUNC_LOAD_WEIGHT;
         req_ch.entry_index <= '0;
         req_ch.component_index <= '0;
         req_ch.value <= '0;
         req_ch.last_component <= 1'b0;
         req_gap = 0;
      end else begin
         busy = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            som_predict(cur);
            busy = 1'b0;
         end
         if (!busy) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_beats.size() != 0 && !calm &&
                         $urandom_range(9) == 0) begin
               req_gap = $urandom_range(13, 1) - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               nxt = pending_beats.pop_front();
               cur = nxt;
               req_ch.valid <= 1'b1;
               req_ch.func <= nxt.func;
               req_ch.entry_index <= nxt.ent;
               req_ch.component_index <= nxt.comp;
               req_ch.value <= nxt.val;
               req_ch.last_component <= nxt.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready control
   int rsp_stall, long_hold;
   bit long_done;
   always @(posedge clock) begin
      som_rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0; long_hold = 0; long_done = 0; rsp_seen = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
               report("unexpected beat, winner", 64'(rsp_ch.winner_index), 0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_ch.winner_index !== want.win)
                  report("winner_index", 64'(rsp_ch.winner_index), 64'(want.win));
               if (rsp_ch.winner_sq_distance !== want.sqd)
                  report("winner_sq_distance", 64'(rsp_ch.winner_sq_distance),
                         64'(want.sqd));
               if (rsp_ch.density_count !== want.dens)
                  report("density_count", 64'(rsp_ch.density_count), 64'(want.dens));
               if (rsp_ch.empty_map !== want.empty)
                  report("empty_map", 64'(rsp_ch.empty_map), 64'(want.empty));
            end
            // one long hold so the core backs up into its request side
            if (rsp_seen == 30 && !long_done) begin
               long_hold = 400; long_done = 1;
            end
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(7) == 0) begin
            rsp_stall = $urandom_range(13, 1) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // register write: setup then access beat
   task automatic csr_write(csr_index_type idx, logic [63:0] data);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= 6'(idx) << 3; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         CSR_ENTRY_COUNT:  r_count = data[6:0];
         CSR_VECTOR_DIMS:  r_vdims = data[4:0];
         CSR_MAP_DIMS:     r_mdims = data[1:0];
         CSR_LEARN_RAY:    r_lray  = data[15:0];
         CSR_LEARN_FACTOR: r_lfac  = data[15:0];
         CSR_DENSITY_RAY:  r_dray  = data[39:0];
         default: ;
      endcase
   endtask

   // sample after the edge has settled so driver and monitor updates are seen
   task automatic wait_idle(int extra);
      @(posedge clock); #1;
      while (pending_beats.size() != 0 || req_ch.valid || expected_rsp.size() != 0) begin
         @(posedge clock); #1;
      end
      repeat (extra) @(posedge clock);
   endtask

   function automatic void push_beat(func_type f, int ent, int comp, logic [15:0] val,
                                     bit last);
      som_req_type r;
      r = '{func: f, ent: 6'(ent), comp: 4'(comp), val: val, last: last};
      pending_beats.insert(pending_beats.size(), r);
      if (f == FUNC_LOAD_WEIGHT) wr_weight[ent][comp] = 1;
      else if (f == FUNC_LOAD_COORD) begin
         if (comp < 2) wr_coord[ent][comp] = 1;
      end else wr_query[comp] = 1;
   endfunction

   function automatic logic [15:0] rnd_value();
      int p;
      p = $urandom_range(99);
      if (p < 5) return 16'h7FFF;
      if (p < 10) return 16'h8000;
      if (p < 55) return 16'($signed($urandom_range(1023)) - 512);
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] rnd_coord();
      if ($urandom_range(9) < 8) return 16'($urandom_range(3));
      return 16'($urandom);
   endfunction

   // load whatever the coming queries will read and has not been written
   function automatic void fill_codebook();
      for (int e = 0; e < eff_count(); e++) begin
         for (int j = 0; j < eff_vdims(); j++)
            if (!wr_weight[e][j]) push_beat(FUNC_LOAD_WEIGHT, e, j, rnd_value(), 0);
         for (int j = 0; j < eff_mdims(); j++)
            if (!wr_coord[e][j]) push_beat(FUNC_LOAD_COORD, e, j, rnd_coord(), 0);
      end
   endfunction

   // query: components in shuffled order, then the final beat if with_last
   function automatic void send_query(func_type f, bit with_last);
      int perm [16];
      int d, k, t;
      bit ready_q;
      d = eff_vdims();
      ready_q = 1;
      for (int j = 0; j < d; j++) if (!wr_query[j]) ready_q = 0;
      if (!(ready_q && with_last && $urandom_range(3) == 0)) begin
         for (int j = 0; j < d; j++) perm[j] = j;
         for (int j = d - 1; j > 0; j--) begin
            k = $urandom_range(j); t = perm[j]; perm[j] = perm[k]; perm[k] = t;
         end
         for (int j = 0; j < d; j++) begin
            if ($urandom_range(9) == 0)
               push_beat(f, $urandom_range(63), $urandom_range(15), rnd_value(), 0);
            push_beat(f, $urandom_range(63), perm[j], rnd_value(), 0);
         end
      end
      if (with_last)
         push_beat(f, $urandom_range(63), $urandom_range(15), rnd_value(), 1);
   endfunction

   function automatic void random_traffic(int beats);
      int stop, p;
      func_type qf;
      stop = pending_beats.size() + beats;
      while (pending_beats.size() < stop) begin
         p  = $urandom_range(99);
         qf = ($urandom_range(1) != 0) ? FUNC_LEARN : FUNC_CLASSIFY;
         if (p < 60) send_query(qf, 1);
         else if (p < 68) send_query(qf, 0);
         else if (p < 85)
            push_beat(FUNC_LOAD_WEIGHT, $urandom_range(63), $urandom_range(15),
                      rnd_value(), $urandom_range(1));
         else
            push_beat(FUNC_LOAD_COORD, $urandom_range(63), $urandom_range(15),
                      rnd_coord(), $urandom_range(1));
      end
   endfunction

   task automatic set_all(int n, int vd, int md, int lray, int lfac, logic [39:0] dray);
      csr_write(CSR_ENTRY_COUNT, 64'(n));
      csr_write(CSR_VECTOR_DIMS, 64'(vd));
      csr_write(CSR_MAP_DIMS, 64'(md));
      csr_write(CSR_LEARN_RAY, 64'(lray));
      csr_write(CSR_LEARN_FACTOR, 64'(lfac));
      csr_write(CSR_DENSITY_RAY, 64'(dray));
   endtask

   initial begin
      logic [95:0] t;
      errors = 0; cycles = 0; calm = 0;
      // exp(-i/256) in Q.16
      t = 96'd1 << 32;
      for (int i = 0; i < 256; i++) begin
         gain_exp[i] = 17'((t + 96'd32768) >> 16);
         t = (t * 96'd4278222805 + (96'd1 << 31)) >> 32;
      end
      r_count = 0; r_vdims = 1; r_mdims = 1;
      r_lray = 16'd1280; r_lfac = 16'd4096; r_dray = 40'd327680;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty map, then extreme weights and ignored coordinate loads
      push_beat(FUNC_CLASSIFY, 0, 0, 16'h7FFF, 1);
      push_beat(FUNC_LEARN, 63, 0, 16'h8000, 1);
      wait_idle(DRAIN);
      set_all(3, 2, 1, 1280, 4096, 40'd327680);
      push_beat(FUNC_LOAD_WEIGHT, 0, 0, 16'h7FFF, 0);
      push_beat(FUNC_LOAD_WEIGHT, 0, 1, 16'h8000, 0);
      push_beat(FUNC_LOAD_WEIGHT, 1, 0, 16'h8000, 0);
      push_beat(FUNC_LOAD_WEIGHT, 1, 1, 16'h7FFF, 0);
      push_beat(FUNC_LOAD_WEIGHT, 2, 0, 16'h0000, 0);
      push_beat(FUNC_LOAD_WEIGHT, 2, 1, 16'h0000, 0);
      push_beat(FUNC_LOAD_COORD, 0, 0, 16'h0000, 0);
      push_beat(FUNC_LOAD_COORD, 1, 0, 16'h0001, 0);
      push_beat(FUNC_LOAD_COORD, 2, 0, 16'hFFFF, 0);
      push_beat(FUNC_LOAD_COORD, 2, 15, 16'h0003, 0);
      push_beat(FUNC_CLASSIFY, 0, 0, 16'h7FFF, 0);
      push_beat(FUNC_CLASSIFY, 0, 1, 16'h8000, 1);
      push_beat(FUNC_LEARN, 0, 15, 16'h7FFF, 1);
      push_beat(FUNC_LEARN, 0, 1, 16'h0000, 1);
      fill_codebook();
      random_traffic(150);
      // sender pause until the core has answered everything
      wait_idle(0);
      random_traffic(100);
      wait_idle(DRAIN);

      // 64 entries, 2-D map, widest radii and gain
      set_all(64, 1, 2, 65535, 65535, 40'hFF_FFFF_FFFF);
      fill_codebook();
      random_traffic(120);
      wait_idle(DRAIN);

      // zero learn radius, minimal gain and density bound
      set_all(2, 16, 1, 0, 1, 40'd1);
      fill_codebook();
      random_traffic(150);
      wait_idle(DRAIN);

      // zero dims act as one
      set_all(5, 0, 0, 2000, 8192, 40'd100000);
      fill_codebook();
      random_traffic(140);
      wait_idle(DRAIN);

      // out-of-range counts saturate
      set_all(100, 2, 3, 1, 40000, 40'd5000000);
      fill_codebook();
      random_traffic(80);
      wait_idle(DRAIN);
      set_all(3, 31, 2, 768, 4096, 40'd50000000);
      fill_codebook();
      random_traffic(120);
      wait_idle(DRAIN);

      // random small settings
      for (int ph = 0; ph < 3; ph++) begin
         set_all($urandom_range(8, 1), $urandom_range(4, 1), $urandom_range(2, 1),
                 $urandom_range(65535, 1), $urandom_range(65535, 1),
                 40'($urandom_range(1 << 22)));
         fill_codebook();
         random_traffic(80);
         wait_idle(DRAIN);
      end

      // last stretch: no idling on either side
      calm = 1;
      set_all(6, 3, 2, 1280, 4096, 40'd327680);
      fill_codebook();
      random_traffic(150);
      wait_idle(DRAIN);

      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/som_pkg.sv
hdl/som_ifs.sv
hdl/self_organizing_map_learner_core.sv
tb/sv/tb_self_organizing_map_learner_core.sv
